// ===== sv/drt_pkg.sv =====
// ---------------------------------------------------------------------------
// drt_pkg
// Shared types and constants for the reference-counted dedup table.
// ---------------------------------------------------------------------------
package drt_pkg;

   localparam int TABLE_ENTRIES_DEF = 256;
   localparam int KEY_W    = 64;
   localparam int OFFSET_W = 48;
   localparam int SIZE_W   = 32;
   localparam int ALGO_W   = 8;
   localparam int REFS_W   = 32;
   localparam int STAT_W   = 64;
   localparam int UNIQUE_W = 17;

   typedef enum logic [1:0] {
      REQ_RETAIN  = 2'd0,
      REQ_LOOKUP  = 2'd1,
      REQ_RELEASE = 2'd2,
      REQ_CLEAR   = 2'd3
   } req_type_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ,
      ST_WRITE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset;
      logic [SIZE_W-1:0]   raw_len;
      logic [SIZE_W-1:0]   stored_len;
      logic [ALGO_W-1:0]   algo;
      logic [REFS_W-1:0]   refs;
   } entry_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic scan_start;
      logic read;
      logic write;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic scan_done;
   } status_type;

endpackage

// ===== sv/dedup_refcount_table.sv =====
// Flow: an accepted item is scanned against every key, its entry is read,
// the table is updated and the result is held until taken (clear requests
// skip the scan and the read). One item is in flight at a time: a new request
// is taken only in idle; the linear key scan does one key memory read per cycle.
// Reset: synchronous, clears all valid bits and counters.
// ---------------------------------------------------------------------------
// dedup_refcount_table
// Reference-counted deduplication table keyed by a 64-bit fingerprint.
// ---------------------------------------------------------------------------
module dedup_refcount_table
   import drt_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_type,
   input  logic [KEY_W-1:0]    req_fingerprint,
   input  logic [OFFSET_W-1:0] req_obj_offset,
   input  logic [SIZE_W-1:0]   req_obj_raw_size,
   input  logic [SIZE_W-1:0]   req_obj_stored_size,
   input  logic [ALGO_W-1:0]   req_obj_algo,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_found,
   output logic                rsp_duplicate,
   output logic [OFFSET_W-1:0] rsp_entry_offset,
   output logic [SIZE_W-1:0]   rsp_entry_raw_size,
   output logic [SIZE_W-1:0]   rsp_entry_stored_size,
   output logic [ALGO_W-1:0]   rsp_entry_algo,
   output logic [REFS_W-1:0]   rsp_entry_refs,
   output logic                rsp_table_full,
   output logic [UNIQUE_W-1:0] rsp_unique_objects,
   output logic [STAT_W-1:0]   rsp_duplicate_objects,
   output logic [STAT_W-1:0]   rsp_saved_bytes,
   output logic [STAT_W-1:0]   rsp_logical_bytes
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   drt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // table datapath
   drt_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_type              (req_type),
      .req_fingerprint       (req_fingerprint),
      .req_obj_offset        (req_obj_offset),
      .req_obj_raw_size      (req_obj_raw_size),
      .req_obj_stored_size   (req_obj_stored_size),
      .req_obj_algo          (req_obj_algo),
      .rsp_found             (rsp_found),
      .rsp_duplicate         (rsp_duplicate),
      .rsp_entry_offset      (rsp_entry_offset),
      .rsp_entry_raw_size    (rsp_entry_raw_size),
      .rsp_entry_stored_size (rsp_entry_stored_size),
      .rsp_entry_algo        (rsp_entry_algo),
      .rsp_entry_refs        (rsp_entry_refs),
      .rsp_table_full        (rsp_table_full),
      .rsp_unique_objects    (rsp_unique_objects),
      .rsp_duplicate_objects (rsp_duplicate_objects),
      .rsp_saved_bytes       (rsp_saved_bytes),
      .rsp_logical_bytes     (rsp_logical_bytes)
   );

endmodule

// ===== sv/drt_ctrl.sv =====
// ---------------------------------------------------------------------------
// drt_ctrl
// Sequencer: accept, scan the table, read the entry, update, respond; a clear skips the scan and the read.
// ---------------------------------------------------------------------------
module drt_ctrl
   import drt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_type == REQ_CLEAR) ? ST_WRITE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) state_in = ST_READ;
         end
         ST_READ:  state_in = ST_WRITE;
         ST_WRITE: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.load       = req_valid;
            cmd.scan_start = req_valid && (req_type != REQ_CLEAR);
         end
         ST_READ:  cmd.read  = 1'b1;
         ST_WRITE: cmd.write = 1'b1;
         ST_RESP:  rsp_valid = 1'b1;
         default:  cmd = '0;
      endcase
   end

endmodule

// ===== sv/drt_dp.sv =====
// ---------------------------------------------------------------------------
// drt_dp
// Datapath: key and entry memories, valid bits, scan, counters, result.
// ---------------------------------------------------------------------------
module drt_dp
   import drt_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic [1:0]          req_type,
   input  logic [KEY_W-1:0]    req_fingerprint,
   input  logic [OFFSET_W-1:0] req_obj_offset,
   input  logic [SIZE_W-1:0]   req_obj_raw_size,
   input  logic [SIZE_W-1:0]   req_obj_stored_size,
   input  logic [ALGO_W-1:0]   req_obj_algo,
   output logic                rsp_found,
   output logic                rsp_duplicate,
   output logic [OFFSET_W-1:0] rsp_entry_offset,
   output logic [SIZE_W-1:0]   rsp_entry_raw_size,
   output logic [SIZE_W-1:0]   rsp_entry_stored_size,
   output logic [ALGO_W-1:0]   rsp_entry_algo,
   output logic [REFS_W-1:0]   rsp_entry_refs,
   output logic                rsp_table_full,
   output logic [UNIQUE_W-1:0] rsp_unique_objects,
   output logic [STAT_W-1:0]   rsp_duplicate_objects,
   output logic [STAT_W-1:0]   rsp_saved_bytes,
   output logic [STAT_W-1:0]   rsp_logical_bytes
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   // memories
   logic [KEY_W-1:0] key_mem [TABLE_ENTRIES];
   entry_type        data_mem [TABLE_ENTRIES];

   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;

   // captured request
   logic [1:0]          type_ff;
   logic [KEY_W-1:0]    key_ff;
   entry_type           new_ff;

   // scan state
   logic             run_ff, run_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             cmp_vld_ff;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic [KEY_W-1:0] key_rd_ff;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic             free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   entry_type        data_rd_ff;

   // counters
   logic [CNT_W-1:0]  live_ff, live_in;
   logic [STAT_W-1:0] dup_ff, dup_in, saved_ff, saved_in, logical_ff, logical_in;

   // result register next values
   logic       found_in, duplicate_in, full_in;
   entry_type  ent_in, wr_ent;
   logic       wr_key, wr_data;
   logic [IDX_W-1:0] wr_idx;
   logic [REFS_W-1:0] refs_dec;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff           <= req_type;
         key_ff            <= req_fingerprint;
         new_ff.offset     <= req_obj_offset;
         new_ff.raw_len    <= req_obj_raw_size;
         new_ff.stored_len <= req_obj_stored_size;
         new_ff.algo       <= req_obj_algo;
         new_ff.refs       <= REFS_W'(1);
      end
   end

   // scan address generation
   always_comb begin
      run_in = run_ff;
      idx_in = idx_ff;
      if (cmd.scan_start) begin
         run_in = 1'b1;
         idx_in = '0;
      end else if (run_ff) begin
         if (idx_ff == LAST_IDX) run_in = 1'b0;
         else idx_in = idx_ff + IDX_W'(1);
      end
   end

   // compare against the key read last cycle, keep first hit and first free
   always_comb begin
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      if (cmd.scan_start) begin
         hit_in  = 1'b0;
         free_in = 1'b0;
      end else if (cmp_vld_ff) begin
         if (valid_ff[cmp_idx_ff] && key_rd_ff == key_ff && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = cmp_idx_ff;
         end
         if (!valid_ff[cmp_idx_ff] && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = cmp_idx_ff;
         end
      end
   end

   assign status.scan_done = cmp_vld_ff && (cmp_idx_ff == LAST_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff     <= 1'b0;
         cmp_vld_ff <= 1'b0;
      end else begin
         run_ff     <= run_in;
         cmp_vld_ff <= run_ff;
      end
      idx_ff      <= idx_in;
      cmp_idx_ff  <= idx_ff;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
   end

   // key memory
   always_ff @(posedge clock) begin
      if (wr_key) key_mem[wr_idx] <= key_ff;
      key_rd_ff <= key_mem[idx_ff];
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (wr_data) data_mem[wr_idx] <= wr_ent;
      if (cmd.read) data_rd_ff <= data_mem[hit_ff ? hit_idx_ff : free_idx_ff];
   end

   assign refs_dec = (data_rd_ff.refs != '0) ? data_rd_ff.refs - REFS_W'(1) : '0;

   // update of table and counters
   always_comb begin
      valid_in     = valid_ff;
      live_in      = live_ff;
      dup_in       = dup_ff;
      saved_in     = saved_ff;
      logical_in   = logical_ff;
      found_in     = 1'b0;
      duplicate_in = 1'b0;
      full_in      = 1'b0;
      ent_in       = '0;
      wr_ent       = data_rd_ff;
      wr_key       = 1'b0;
      wr_data      = 1'b0;
      wr_idx       = hit_ff ? hit_idx_ff : free_idx_ff;
      case (req_type_type'(type_ff))
         REQ_RETAIN: begin
            if (hit_ff) begin
               if (data_rd_ff.refs != '1) wr_ent.refs = data_rd_ff.refs + REFS_W'(1);
               wr_data      = cmd.write;
               dup_in       = dup_ff + STAT_W'(1);
               saved_in     = saved_ff + STAT_W'(new_ff.stored_len);
               logical_in   = logical_ff + STAT_W'(new_ff.raw_len);
               found_in     = 1'b1;
               duplicate_in = 1'b1;
               ent_in       = wr_ent;
            end else if (free_ff) begin
               wr_ent             = new_ff;
               wr_data            = cmd.write;
               wr_key             = cmd.write;
               valid_in[free_idx_ff] = 1'b1;
               live_in            = live_ff + CNT_W'(1);
               logical_in         = logical_ff + STAT_W'(new_ff.raw_len);
               found_in           = 1'b1;
               ent_in             = new_ff;
            end else begin
               full_in = 1'b1;
            end
         end
         REQ_LOOKUP: begin
            if (hit_ff) begin
               found_in = 1'b1;
               ent_in   = data_rd_ff;
            end
         end
         REQ_RELEASE: begin
            if (hit_ff) begin
               wr_ent.refs = refs_dec;
               if (refs_dec == '0) begin
                  valid_in[hit_idx_ff] = 1'b0;
                  if (live_ff != '0) live_in = live_ff - CNT_W'(1);
               end else begin
                  wr_data  = cmd.write;
                  found_in = 1'b1;
                  ent_in   = wr_ent;
               end
            end
         end
         REQ_CLEAR: begin
            valid_in   = '0;
            live_in    = '0;
            dup_in     = '0;
            saved_in   = '0;
            logical_in = '0;
         end
         default: ent_in = '0;
      endcase
   end

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         live_ff    <= '0;
         dup_ff     <= '0;
         saved_ff   <= '0;
         logical_ff <= '0;
      end else if (cmd.write) begin
         valid_ff   <= valid_in;
         live_ff    <= live_in;
         dup_ff     <= dup_in;
         saved_ff   <= saved_in;
         logical_ff <= logical_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         rsp_found             <= found_in;
         rsp_duplicate         <= duplicate_in;
         rsp_table_full        <= full_in;
         rsp_entry_offset      <= ent_in.offset;
         rsp_entry_raw_size    <= ent_in.raw_len;
         rsp_entry_stored_size <= ent_in.stored_len;
         rsp_entry_algo        <= ent_in.algo;
         rsp_entry_refs        <= ent_in.refs;
         rsp_unique_objects    <= UNIQUE_W'(live_in);
         rsp_duplicate_objects <= dup_in;
         rsp_saved_bytes       <= saved_in;
         rsp_logical_bytes     <= logical_in;
      end
   end

endmodule

// ===== sv/drt_checker.sv =====
// ---------------------------------------------------------------------------
// drt_checker
// Port-level checks for the dedup table, bound to the top level.
// ---------------------------------------------------------------------------
module drt_checker
   import drt_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_found,
   input logic              rsp_duplicate,
   input logic              rsp_table_full,
   input logic [REFS_W-1:0] rsp_entry_refs
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_refs))
      else $error("result changed while stalled");

   // one item in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a result is pending");

   // a full table never reports a found entry
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> !rsp_found && !rsp_duplicate)
      else $error("full table with found entry");

   // a missing entry shows no references and no duplicate
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_entry_refs == '0 && !rsp_duplicate)
      else $error("missing entry with nonzero fields");

endmodule

bind dedup_refcount_table drt_checker u_drt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_found      (rsp_found),
   .rsp_duplicate  (rsp_duplicate),
   .rsp_table_full (rsp_table_full),
   .rsp_entry_refs (rsp_entry_refs)
);

// ===== tb/sv/dedup_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dedup_checker
// Watches the request and response channels of the dedup table, keeps a
// shadow copy of the table and its statistics, predicts each response and
// compares it field by field with what the block returns.
// ---------------------------------------------------------------------------
module dedup_checker
   import drt_pkg::*;
#(
   parameter int ENTRIES = TABLE_ENTRIES_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [1:0]          req_type,
   input  logic [KEY_W-1:0]    req_fingerprint,
   input  logic [OFFSET_W-1:0] req_obj_offset,
   input  logic [SIZE_W-1:0]   req_obj_raw_size,
   input  logic [SIZE_W-1:0]   req_obj_stored_size,
   input  logic [ALGO_W-1:0]   req_obj_algo,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic                rsp_found,
   input  logic                rsp_duplicate,
   input  logic [OFFSET_W-1:0] rsp_entry_offset,
   input  logic [SIZE_W-1:0]   rsp_entry_raw_size,
   input  logic [SIZE_W-1:0]   rsp_entry_stored_size,
   input  logic [ALGO_W-1:0]   rsp_entry_algo,
   input  logic [REFS_W-1:0]   rsp_entry_refs,
   input  logic                rsp_table_full,
   input  logic [UNIQUE_W-1:0] rsp_unique_objects,
   input  logic [STAT_W-1:0]   rsp_duplicate_objects,
   input  logic [STAT_W-1:0]   rsp_saved_bytes,
   input  logic [STAT_W-1:0]   rsp_logical_bytes,
   output int                  errors,
   output int                  pending,
   output int                  checked,
   output int                  full_hits,
   output int                  dup_hits,
   output int                  frees
);

   typedef struct packed {
      logic                found;
      logic                duplicate;
      logic [OFFSET_W-1:0] offset;
      logic [SIZE_W-1:0]   raw_len;
      logic [SIZE_W-1:0]   stored_len;
      logic [ALGO_W-1:0]   algo;
      logic [REFS_W-1:0]   refs;
      logic                table_full;
      logic [UNIQUE_W-1:0] unique_objs;
      logic [STAT_W-1:0]   dup_objs;
      logic [STAT_W-1:0]   saved;
      logic [STAT_W-1:0]   logical;
   } table_rsp_type;

   // shadow table
   logic                shadow_valid [ENTRIES];
   logic [KEY_W-1:0]    shadow_key   [ENTRIES];
   entry_type           shadow_entry [ENTRIES];
   logic [UNIQUE_W-1:0] shadow_live;
   logic [STAT_W-1:0]   shadow_dups;
   logic [STAT_W-1:0]   shadow_saved;
   logic [STAT_W-1:0]   shadow_logical;

   table_rsp_type expected_rsps [$];

   function automatic int find_key(input logic [KEY_W-1:0] key);
      for (int i = 0; i < ENTRIES; i++)
         if (shadow_valid[i] && shadow_key[i] == key) return i;
      return -1;
   endfunction

   function automatic int lowest_free();
      for (int i = 0; i < ENTRIES; i++)
         if (!shadow_valid[i]) return i;
      return -1;
   endfunction

   function automatic void wipe_table();
      for (int i = 0; i < ENTRIES; i++) shadow_valid[i] = 1'b0;
      shadow_live    = '0;
      shadow_dups    = '0;
      shadow_saved   = '0;
      shadow_logical = '0;
   endfunction

   // apply one request to the shadow table and build its response
   function automatic table_rsp_type apply_request();
      table_rsp_type r;
      int slot;
      r = '0;
      slot = -1;
      case (req_type_type'(req_type))
         REQ_RETAIN: begin
            slot = find_key(req_fingerprint);
            if (slot >= 0) begin
               if (shadow_entry[slot].refs != '1)
                  shadow_entry[slot].refs = shadow_entry[slot].refs + REFS_W'(1);
               shadow_dups    = shadow_dups + STAT_W'(1);
               shadow_saved   = shadow_saved + STAT_W'(req_obj_stored_size);
               shadow_logical = shadow_logical + STAT_W'(req_obj_raw_size);
               r.duplicate    = 1'b1;
               dup_hits++;
            end else begin
               slot = lowest_free();
               if (slot < 0) begin
                  r.table_full = 1'b1;
                  full_hits++;
               end else begin
                  shadow_valid[slot]            = 1'b1;
                  shadow_key[slot]              = req_fingerprint;
                  shadow_entry[slot].offset     = req_obj_offset;
                  shadow_entry[slot].raw_len    = req_obj_raw_size;
                  shadow_entry[slot].stored_len = req_obj_stored_size;
                  shadow_entry[slot].algo       = req_obj_algo;
                  shadow_entry[slot].refs       = REFS_W'(1);
                  shadow_live    = shadow_live + UNIQUE_W'(1);
                  shadow_logical = shadow_logical + STAT_W'(req_obj_raw_size);
               end
            end
         end
         REQ_LOOKUP: slot = find_key(req_fingerprint);
         REQ_RELEASE: begin
            slot = find_key(req_fingerprint);
            if (slot >= 0) begin
               if (shadow_entry[slot].refs != '0)
                  shadow_entry[slot].refs = shadow_entry[slot].refs - REFS_W'(1);
               if (shadow_entry[slot].refs == '0) begin
                  shadow_valid[slot] = 1'b0;
                  if (shadow_live != '0) shadow_live = shadow_live - UNIQUE_W'(1);
                  slot = -1;
                  frees++;
               end
            end
         end
         default: wipe_table();
      endcase
      if (slot >= 0) begin
         r.found      = 1'b1;
         r.offset     = shadow_entry[slot].offset;
         r.raw_len    = shadow_entry[slot].raw_len;
         r.stored_len = shadow_entry[slot].stored_len;
         r.algo       = shadow_entry[slot].algo;
         r.refs       = shadow_entry[slot].refs;
      end
      r.unique_objs = shadow_live;
      r.dup_objs    = shadow_dups;
      r.saved       = shadow_saved;
      r.logical     = shadow_logical;
      return r;
   endfunction

   // compare one returned item with the oldest prediction
   function automatic void compare_rsp();
      table_rsp_type exp_r, got;
      got = '{rsp_found, rsp_duplicate, rsp_entry_offset, rsp_entry_raw_size,
              rsp_entry_stored_size, rsp_entry_algo, rsp_entry_refs,
              rsp_table_full, rsp_unique_objects, rsp_duplicate_objects,
              rsp_saved_bytes, rsp_logical_bytes};
      checked++;
      if (expected_rsps.size() == 0) begin
         errors++;
         if (errors <= 10) $display("error: response item with none expected");
         return;
      end
      exp_r = expected_rsps.pop_front();
      if (got.found !== exp_r.found || got.duplicate !== exp_r.duplicate ||
          got.offset !== exp_r.offset || got.raw_len !== exp_r.raw_len ||
          got.stored_len !== exp_r.stored_len || got.algo !== exp_r.algo ||
          got.refs !== exp_r.refs || got.table_full !== exp_r.table_full ||
          got.unique_objs !== exp_r.unique_objs ||
          got.dup_objs !== exp_r.dup_objs || got.saved !== exp_r.saved ||
          got.logical !== exp_r.logical) begin
         errors++;
         if (errors <= 10) begin
            $display("error: response item %0d differs", checked);
            $display("  exp found=%b dup=%b off=%h raw=%h sto=%h algo=%h refs=%h full=%b",
                     exp_r.found, exp_r.duplicate, exp_r.offset, exp_r.raw_len,
                     exp_r.stored_len, exp_r.algo, exp_r.refs, exp_r.table_full);
            $display("  got found=%b dup=%b off=%h raw=%h sto=%h algo=%h refs=%h full=%b",
                     got.found, got.duplicate, got.offset, got.raw_len,
                     got.stored_len, got.algo, got.refs, got.table_full);
            $display("  exp uniq=%h dups=%h saved=%h logical=%h", exp_r.unique_objs,
                     exp_r.dup_objs, exp_r.saved, exp_r.logical);
            $display("  got uniq=%h dups=%h saved=%h logical=%h", got.unique_objs,
                     got.dup_objs, got.saved, got.logical);
         end
      end
   endfunction

   // request first, so a same-edge response still finds its prediction
   always @(posedge clock) begin
      if (reset) begin
         wipe_table();
         expected_rsps.delete();
      end else begin
         if (req_valid && req_ready) expected_rsps.push_back(apply_request());
         if (rsp_valid && rsp_ready) compare_rsp();
      end
      pending <= expected_rsps.size();
   end

   initial begin
      errors    = 0;
      pending   = 0;
      checked   = 0;
      full_hits = 0;
      dup_hits  = 0;
      frees     = 0;
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives the dedup table with directed and random requests over a small
// key pool, one table-fill pass and varying idle patterns on both sides;
// the checker predicts and compares every response.
// ---------------------------------------------------------------------------
module testbench;
   import drt_pkg::*;

   localparam int ENTRIES      = TABLE_ENTRIES_DEF;
   localparam int RANDOM_ITEMS = 700;
   localparam int CYCLE_LIMIT  = 3000000;
   localparam int POOL_SIZE    = 24;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [1:0]          req_type;
   logic [KEY_W-1:0]    req_fingerprint;
   logic [OFFSET_W-1:0] req_obj_offset;
   logic [SIZE_W-1:0]   req_obj_raw_size;
   logic [SIZE_W-1:0]   req_obj_stored_size;
   logic [ALGO_W-1:0]   req_obj_algo;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_found;
   logic                rsp_duplicate;
   logic [OFFSET_W-1:0] rsp_entry_offset;
   logic [SIZE_W-1:0]   rsp_entry_raw_size;
   logic [SIZE_W-1:0]   rsp_entry_stored_size;
   logic [ALGO_W-1:0]   rsp_entry_algo;
   logic [REFS_W-1:0]   rsp_entry_refs;
   logic                rsp_table_full;
   logic [UNIQUE_W-1:0] rsp_unique_objects;
   logic [STAT_W-1:0]   rsp_duplicate_objects;
   logic [STAT_W-1:0]   rsp_saved_bytes;
   logic [STAT_W-1:0]   rsp_logical_bytes;

   int errors, pending, checked, full_hits, dup_hits, frees;
   int send_idle_pct, recv_idle_pct, hold_cycles, cycles, sent;
   logic [KEY_W-1:0] key_pool [POOL_SIZE];

   dedup_refcount_table u_top (.*);

   dedup_checker #(.ENTRIES(ENTRIES)) u_checker (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // response side: random stalls plus an occasional long hold-off
   initial begin
      rsp_ready   = 1'b0;
      hold_cycles = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // extremes or, mostly, full-range random values
   function automatic logic [63:0] pick_value();
      case ($urandom_range(5))
         0:       return '0;
         1:       return '1;
         default: return rand64();
      endcase
   endfunction

   // present one item and wait for it to be taken; called at a falling edge
   task automatic send_item(input req_type_type kind, input logic [63:0] key,
                            input logic [63:0] off, input logic [31:0] raw,
                            input logic [31:0] sto, input logic [7:0] algo);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid           = 1'b1;
      req_type            = kind;
      req_fingerprint     = key;
      req_obj_offset      = off[OFFSET_W-1:0];
      req_obj_raw_size    = raw;
      req_obj_stored_size = sto;
      req_obj_algo        = algo;
      do @(posedge clock); while (!req_ready);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_random(input req_type_type kind, input logic [63:0] key);
      send_item(kind, key, pick_value(), 32'(pick_value()), 32'(pick_value()),
                8'(pick_value()));
   endtask

   // pause the sender until every response has come back
   task automatic drain();
      req_valid = 1'b0;
      do @(negedge clock); while (pending != 0 || rsp_valid);
   endtask

   task automatic random_phase(input int count);
      int roll;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 48)
            send_random(REQ_RETAIN, key_pool[$urandom_range(POOL_SIZE-1)]);
         else if (roll < 68)
            send_random(REQ_LOOKUP, key_pool[$urandom_range(POOL_SIZE-1)]);
         else if (roll < 96)
            send_random(REQ_RELEASE, key_pool[$urandom_range(POOL_SIZE-1)]);
         else if (roll < 98)
            send_random(REQ_LOOKUP, rand64());
         else
            send_random(REQ_CLEAR, rand64());
      end
   endtask

   initial begin
      sent                = 0;
      send_idle_pct       = 0;
      recv_idle_pct       = 0;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_type            = REQ_LOOKUP;
      req_fingerprint     = '0;
      req_obj_offset      = '0;
      req_obj_raw_size    = '0;
      req_obj_stored_size = '0;
      req_obj_algo        = '0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = rand64();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: misses, extremes, duplicates, release to zero, slot reuse
      send_item(REQ_LOOKUP,  '1, '0, '0, '0, '0);
      send_item(REQ_RELEASE, '0, '1, '1, '1, '1);
      send_item(REQ_RETAIN,  '0, '1, '1, '1, '1);
      send_item(REQ_RETAIN,  '1, '0, '0, '0, '0);
      send_item(REQ_RETAIN,  '0, '0, '1, '1, '0);
      send_item(REQ_RETAIN,  '0, '1, 32'h1234, 32'h5678, '1);
      send_item(REQ_LOOKUP,  '0, '0, '0, '0, '0);
      send_item(REQ_LOOKUP,  '1, '1, '1, '1, '1);
      send_item(REQ_RELEASE, '0, '0, '0, '0, '0);
      send_item(REQ_RELEASE, '1, '0, '0, '0, '0);
      send_item(REQ_LOOKUP,  '1, '0, '0, '0, '0);
      send_item(REQ_RETAIN,  64'h5555_5555_5555_5555, 64'h5555_5555_5555, 32'haaaa_aaaa,
                32'h5555_5555, 8'haa);
      send_item(REQ_RETAIN,  64'haaaa_aaaa_aaaa_aaaa, 64'haaaa_aaaa_aaaa, 32'h5555_5555,
                32'haaaa_aaaa, 8'h55);
      send_item(REQ_RELEASE, '0, '0, '0, '0, '0);
      send_item(REQ_RELEASE, '0, '0, '0, '0, '0);
      send_item(REQ_RELEASE, '0, '0, '0, '0, '0);
      send_item(REQ_RETAIN,  64'h1, 64'h1, 32'h1, 32'h1, 8'h1);
      send_item(REQ_LOOKUP,  64'h1, '0, '0, '0, '0);
      send_item(REQ_CLEAR,   '1, '1, '1, '1, '1);
      send_item(REQ_LOOKUP,  64'h1, '0, '0, '0, '0);
      drain();

      // fill the table, overflow it, release an absent key, retry and clear it
      send_idle_pct = 10;
      recv_idle_pct = 30;
      for (int i = 0; i < ENTRIES; i++)
         send_random(REQ_RETAIN, {$urandom, 24'h0, i[7:0]});
      send_random(REQ_RETAIN, rand64());
      send_random(REQ_RETAIN, '1);
      send_random(REQ_RETAIN, {$urandom, 24'h0, 8'd7});
      send_random(REQ_RELEASE, rand64());
      send_random(REQ_RETAIN, rand64());
      send_random(REQ_CLEAR, '0);

      // long receiver hold-off while the sender keeps offering items
      hold_cycles = 2000;
      random_phase(6);
      drain();

      send_idle_pct = 22;
      recv_idle_pct = 87;
      random_phase(RANDOM_ITEMS / 3);
      drain();
      send_idle_pct = 87;
      recv_idle_pct = 22;
      random_phase(RANDOM_ITEMS / 3);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(RANDOM_ITEMS / 3);

      drain();
      repeat (ENTRIES + 20) @(posedge clock);
      $display("sent %0d request items, checked %0d responses", sent, checked);
      $display("duplicates %0d, entries freed %0d, full-table inserts %0d",
               dup_hits, frees, full_hits);
      if (errors == 0 && pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
